/* sv/pwbm_pkg.sv */
// ---------------------------------------------------------------------------
// pwbm_pkg
// Shared constants, codes and types of the page window buffer manager.
// ---------------------------------------------------------------------------
package pwbm_pkg;

	localparam int PAGE_BITS = 14;
	localparam int PAGE_SIZE = 1 << PAGE_BITS;
	localparam int BUFFERS   = 8;
	localparam int ENT_W     = 3;
	localparam int POS_W     = 31;
	localparam int PN_W      = POS_W - PAGE_BITS;
	localparam int LEN_W     = PAGE_BITS + 1;
	localparam int CNT_W     = 4;

	localparam logic [1:0] MODE_INIT = 2'd0;
	localparam logic [1:0] MODE_SEEK = 2'd1;
	localparam logic [1:0] MODE_NEXT = 2'd2;
	localparam logic [1:0] MODE_PREV = 2'd3;

	localparam logic [1:0] ST_BYTE = 2'd0;
	localparam logic [1:0] ST_EOF  = 2'd1;
	localparam logic [1:0] ST_POS  = 2'd2;

	localparam logic [1:0] CMD_HOLD = 2'd0;
	localparam logic [1:0] CMD_SHL  = 2'd1;
	localparam logic [1:0] CMD_SHR  = 2'd2;
	localparam logic [1:0] CMD_LOAD = 2'd3;

	localparam logic CFG_FILE_SIZE    = 1'b0;
	localparam logic CFG_BUFFER_COUNT = 1'b1;

	typedef struct packed {
		logic [1:0]       mode;
		logic [POS_W-1:0] offset;
	} in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [ENT_W-1:0]   byte_slot;
		logic [PAGE_BITS-1:0] byte_index;
		logic [POS_W-1:0]   position;
		logic               load_valid;
		logic [ENT_W-1:0]   load_slot;
		logic [POS_W-1:0]   load_base;
	} out_t;

	typedef struct packed {
		logic [PN_W-1:0]  pn;
		logic [LEN_W-1:0] len;
		logic [ENT_W-1:0] slot;
	} entry_t;

	typedef struct packed {
		logic [1:0] cmd;
		entry_t     fill;
	} cell_ctl_t;

endpackage

/* sv/pwbm_cell.sv */
// ---------------------------------------------------------------------------
// pwbm_cell
// One window descriptor: shifts toward either neighbor, loads, or holds.
// ---------------------------------------------------------------------------
module pwbm_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [pwbm_pkg::ENT_W-1:0]    reset_slot,
	input  pwbm_pkg::cell_ctl_t           ctl,
	input  pwbm_pkg::entry_t              left,
	input  pwbm_pkg::entry_t              right,
	input  logic [pwbm_pkg::PN_W-1:0]     target_pg,
	output pwbm_pkg::entry_t              ent,
	output logic                          hit
);

	pwbm_pkg::entry_t ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q.pn   <= '0;
			ent_q.len  <= '0;
			ent_q.slot <= reset_slot;
		end else begin
			case (ctl.cmd)
				pwbm_pkg::CMD_SHL:  ent_q <= right;
				pwbm_pkg::CMD_SHR:  ent_q <= left;
				pwbm_pkg::CMD_LOAD: ent_q <= ctl.fill;
				default:            ent_q <= ent_q;
			endcase
		end
	end

	assign ent = ent_q;
	assign hit = (ent_q.pn == target_pg);

endmodule

/* sv/page_window_buffer_manager.sv */
// ---------------------------------------------------------------------------
// page_window_buffer_manager
// Ordered window of page descriptors held in a chain of cells.
// ---------------------------------------------------------------------------
// A command word (init, seek, next byte, previous byte) enters on in_valid and
// in_ready. It is captured into a register and resolved from there, and no new
// word is taken until the held word has been resolved. Each command
// yields exactly one result word on out_valid and out_ready, holding the byte
// location, the cursor and any page load request. The result sits in an
// output register, so the next command is accepted while it waits; when the
// receiver stalls, the resolve cycle waits until the register frees.
// The descriptors live in a row of cells that shift toward the older or the
// newer end of the window as pages are recycled. Configuration words on
// cfg_valid and cfg_ready set the file size and the usable buffer count and
// are always accepted. Reset empties the window, sets file size to zero and
// the buffer count to eight, and gives entry i slot i.
// ---------------------------------------------------------------------------
module page_window_buffer_manager (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  pwbm_pkg::in_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output pwbm_pkg::out_t                out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [pwbm_pkg::POS_W-1:0]    cfg_data
);

	localparam int NB = pwbm_pkg::BUFFERS;
	localparam int PB = pwbm_pkg::PAGE_BITS;
	localparam int PW = pwbm_pkg::PN_W;
	localparam int LW = pwbm_pkg::LEN_W;
	localparam int EW = pwbm_pkg::ENT_W;
	localparam int CW = pwbm_pkg::CNT_W;
	localparam int XW = pwbm_pkg::POS_W;

	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_FWD   = 2'd1;
	localparam logic [1:0] ACT_BACK  = 2'd2;
	localparam logic [1:0] ACT_FRESH = 2'd3;

	logic [XW-1:0]     fsize_q;
	logic [CW-1:0]     bcnt_q;
	logic [CW-1:0]     wc_q;
	logic [EW-1:0]     cur_q;
	logic [XW-1:0]     cursor_q;
	logic              busy_q;
	pwbm_pkg::in_t     in_q;
	logic              out_valid_q;
	pwbm_pkg::out_t    out_q;

	pwbm_pkg::entry_t    ent [NB];
	pwbm_pkg::cell_ctl_t ctl [NB];
	logic [NB-1:0]       hitv;

	logic              go;
	pwbm_pkg::entry_t  cur_e, nx_e, pv_e;
	logic [XW-1:0]     base;
	logic              wc_nz, rec;
	logic [CW-1:0]     ucnt, wc_m1, fwd_wc;
	logic [EW-1:0]     fe, first_idx;
	logic [EW-1:0]     fslot, bslot_new;
	logic [PW-1:0]     opg, nb_pg;
	logic [XW-1:0]     nb_base, fdiff;
	logic [LW-1:0]     len_new;
	logic              hit_cur, found;
	logic [1:0]        act;
	logic [CW-1:0]     wc_n;
	logic [EW-1:0]     cur_n;
	logic [XW-1:0]     npos;
	pwbm_pkg::out_t    res;
	logic [PW-1:0]     tpn;
	logic [LW-1:0]     tlen;
	logic [EW-1:0]     tslot;
	logic [XW-1:0]     tbase;

	assign go        = busy_q && (!out_valid_q || out_ready);
	assign in_ready  = !busy_q;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	for (genvar g = 0; g < NB; g++) begin : g_cell
		pwbm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.reset_slot (EW'(g)),
			.ctl        (ctl[g]),
			.left       (ent[(g == 0) ? 0 : g - 1]),
			.right      (ent[(g == NB - 1) ? g : g + 1]),
			.target_pg  (opg),
			.ent        (ent[g]),
			.hit        (hitv[g])
		);
	end

	always_comb begin
		cur_e   = ent[cur_q];
		base    = {cur_e.pn, {PB{1'b0}}};
		wc_nz   = (wc_q != '0);
		wc_m1   = wc_q - CW'(1);
		if (bcnt_q > CW'(NB)) begin
			ucnt = CW'(NB);
		end else if (bcnt_q == '0) begin
			ucnt = CW'(1);
		end else begin
			ucnt = bcnt_q;
		end
		rec     = wc_nz && (wc_q >= ucnt);
		fe      = rec ? wc_m1[EW-1:0] : wc_q[EW-1:0];
		fslot   = rec ? ent[0].slot : ent[wc_q[EW-1:0]].slot;
		fwd_wc  = rec ? wc_q : wc_q + CW'(1);
		bslot_new = ent[wc_m1[EW-1:0]].slot;
		nx_e    = ent[cur_q + EW'(1)];
		pv_e    = ent[cur_q - EW'(1)];
		opg     = in_q.offset[XW-1:PB];

		case (in_q.mode)
			pwbm_pkg::MODE_INIT: nb_pg = '0;
			pwbm_pkg::MODE_SEEK: nb_pg = opg;
			pwbm_pkg::MODE_NEXT: nb_pg = cur_e.pn + PW'(1);
			default:             nb_pg = cur_e.pn - PW'(1);
		endcase
		nb_base = {nb_pg, {PB{1'b0}}};
		fdiff   = fsize_q - nb_base;
		if (nb_base >= fsize_q) begin
			len_new = '0;
		end else if (fdiff > XW'(pwbm_pkg::PAGE_SIZE)) begin
			len_new = LW'(pwbm_pkg::PAGE_SIZE);
		end else begin
			len_new = fdiff[LW-1:0];
		end

		first_idx = '0;
		for (int i = NB - 1; i >= 0; i--) begin
			if (hitv[i] && (CW'(i) < wc_q)) begin
				first_idx = EW'(i);
			end
		end
		hit_cur = wc_nz && (cur_e.pn == opg);
		found   = hit_cur;
		for (int i = 0; i < NB; i++) begin
			if (hitv[i] && (CW'(i) < wc_q)) begin
				found = 1'b1;
			end
		end

		act   = ACT_NONE;
		wc_n  = wc_q;
		cur_n = cur_q;
		npos  = cursor_q;
		res   = '0;
		res.status = pwbm_pkg::ST_EOF;
		res.position = cursor_q;
		tpn   = pv_e.pn;
		tlen  = pv_e.len;
		tslot = pv_e.slot;
		tbase = '0;

		case (in_q.mode)
			pwbm_pkg::MODE_INIT: begin
				act            = ACT_FRESH;
				wc_n           = CW'(1);
				cur_n          = '0;
				npos           = '0;
				res.load_valid = 1'b1;
				res.load_slot  = ent[0].slot;
				res.status     = pwbm_pkg::ST_POS;
			end
			pwbm_pkg::MODE_SEEK: begin
				if (found) begin
					if (!hit_cur) begin
						cur_n = first_idx;
					end
				end else begin
					res.load_valid = 1'b1;
					res.load_base  = nb_base;
					if (wc_nz && ({1'b0, opg} == {1'b0, cur_e.pn} + (PW+1)'(1))) begin
						act           = ACT_FWD;
						cur_n         = fe;
						wc_n          = fwd_wc;
						res.load_slot = fslot;
					end else if (wc_nz && (cur_e.pn != '0)
							&& (opg == cur_e.pn - PW'(1))) begin
						act           = ACT_BACK;
						cur_n         = '0;
						res.load_slot = bslot_new;
					end else begin
						act           = ACT_FRESH;
						wc_n          = CW'(1);
						cur_n         = '0;
						res.load_slot = ent[0].slot;
					end
				end
				npos       = in_q.offset;
				res.status = pwbm_pkg::ST_POS;
			end
			pwbm_pkg::MODE_NEXT: begin
				if (!wc_nz) begin
					res.status = pwbm_pkg::ST_EOF;
				end else if ({1'b0, cursor_q} < {1'b0, base} + (XW+1)'(cur_e.len)) begin
					res.status     = pwbm_pkg::ST_BYTE;
					res.byte_slot  = cur_e.slot;
					res.byte_index = cursor_q[PB-1:0];
					npos           = cursor_q + XW'(1);
				end else if (cur_e.len < LW'(pwbm_pkg::PAGE_SIZE)) begin
					res.status = pwbm_pkg::ST_EOF;
				end else if ({1'b0, cur_q} + CW'(1) >= wc_q) begin
					act            = ACT_FWD;
					wc_n           = fwd_wc;
					res.load_valid = 1'b1;
					res.load_slot  = fslot;
					res.load_base  = nb_base;
					if (len_new == '0) begin
						if (rec && (cur_q != '0)) begin
							cur_n = cur_q - EW'(1);
						end
					end else begin
						cur_n          = fe;
						npos           = nb_base + XW'(1);
						res.status     = pwbm_pkg::ST_BYTE;
						res.byte_slot  = fslot;
					end
				end else begin
					cur_n = cur_q + EW'(1);
					npos  = {nx_e.pn, {PB{1'b0}}};
					if (nx_e.len != '0) begin
						res.status    = pwbm_pkg::ST_BYTE;
						res.byte_slot = nx_e.slot;
						npos          = {nx_e.pn, {PB{1'b0}}} + XW'(1);
					end
				end
			end
			default: begin
				if (!wc_nz) begin
					res.status = pwbm_pkg::ST_EOF;
				end else if (cursor_q > base) begin
					npos           = cursor_q - XW'(1);
					res.status     = pwbm_pkg::ST_BYTE;
					res.byte_slot  = cur_e.slot;
					res.byte_index = npos[PB-1:0];
				end else if (cur_e.pn == '0) begin
					res.status = pwbm_pkg::ST_EOF;
				end else begin
					if (cur_q == '0) begin
						act            = ACT_BACK;
						res.load_valid = 1'b1;
						res.load_slot  = bslot_new;
						res.load_base  = nb_base;
						cur_n          = '0;
						tpn            = nb_pg;
						tlen           = len_new;
						tslot          = bslot_new;
					end else begin
						cur_n = cur_q - EW'(1);
					end
					tbase = {tpn, {PB{1'b0}}};
					if (tlen == '0) begin
						npos = tbase;
					end else begin
						npos           = tbase + XW'(tlen) - XW'(1);
						res.status     = pwbm_pkg::ST_BYTE;
						res.byte_slot  = tslot;
						res.byte_index = PB'(tlen - LW'(1));
					end
				end
			end
		endcase
		res.position = npos;

		for (int i = 0; i < NB; i++) begin
			ctl[i].cmd       = pwbm_pkg::CMD_HOLD;
			ctl[i].fill.pn   = nb_pg;
			ctl[i].fill.len  = len_new;
			ctl[i].fill.slot = ent[0].slot;
			if (go) begin
				case (act)
					ACT_FWD: begin
						ctl[i].fill.slot = fslot;
						if (rec && (EW'(i) < fe)) begin
							ctl[i].cmd = pwbm_pkg::CMD_SHL;
						end else if (EW'(i) == fe) begin
							ctl[i].cmd = pwbm_pkg::CMD_LOAD;
						end
					end
					ACT_BACK: begin
						ctl[i].fill.slot = bslot_new;
						if (i == 0) begin
							ctl[i].cmd = pwbm_pkg::CMD_LOAD;
						end else if (CW'(i) < wc_q) begin
							ctl[i].cmd = pwbm_pkg::CMD_SHR;
						end
					end
					ACT_FRESH: begin
						if (i == 0) begin
							ctl[i].cmd = pwbm_pkg::CMD_LOAD;
						end
					end
					default: begin
						ctl[i].cmd = pwbm_pkg::CMD_HOLD;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsize_q     <= '0;
			bcnt_q      <= CW'(8);
			wc_q        <= '0;
			cur_q       <= '0;
			cursor_q    <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					pwbm_pkg::CFG_FILE_SIZE:    fsize_q <= cfg_data;
					pwbm_pkg::CFG_BUFFER_COUNT: bcnt_q  <= cfg_data[CW-1:0];
					default:                    fsize_q <= fsize_q;
				endcase
			end
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
			end else if (go) begin
				busy_q <= 1'b0;
			end
			if (go) begin
				wc_q        <= wc_n;
				cur_q       <= cur_n;
				cursor_q    <= npos;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_q <= in_data;
		end
		if (go) begin
			out_q <= res;
		end
	end

`ifndef ASSERT_OFF
	a_wc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wc_q <= CW'(NB))
		else $error("window count exceeds buffer count");
	a_cur_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(wc_q != '0) |-> ({1'b0, cur_q} < wc_q))
		else $error("current entry outside window");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && out_valid_q && !out_ready) |=> busy_q)
		else $error("command resolved while result stalled");
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> out_valid_q)
		else $error("resolved command produced no result");
`endif

endmodule
